/* rtl/ppp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ppp_pkg
// Shared types, widths and helpers of the perspective point projector.
// ----------------------------------------------------------------------------
package ppp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int COEF_FRAC = 14;
    localparam int DIV_STEPS = 31;
    localparam int SUM_W     = 51;
    localparam int MAG_W     = 50;
    localparam int SAT_IN_W  = 66;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = 2;
    localparam int Q_CNT_W   = 3;

    localparam logic [2:0] REG_POS_X = 3'd0;
    localparam logic [2:0] REG_POS_Y = 3'd1;
    localparam logic [2:0] REG_POS_Z = 3'd2;
    localparam logic [2:0] REG_DIR   = 3'd3;
    localparam logic [2:0] REG_ZOOM  = 3'd4;
    localparam logic [2:0] REG_ROW_U = 3'd5;
    localparam logic [2:0] REG_ROW_W = 3'd6;

    localparam logic signed [SUM_W-1:0] SCREEN_X_FX = SUM_W'(500) <<< FRAC_BITS;
    localparam logic signed [SUM_W-1:0] SCREEN_Y_FX = SUM_W'(400) <<< FRAC_BITS;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [47:0]        dir;
        logic [30:0]        zoom;
        logic [47:0]        row_u;
        logic [47:0]        row_w;
    } t_cfg;

    typedef struct packed {
        logic [MAG_W-1:0]   an;
        logic [MAG_W-1:0]   ad;
        logic               neg;
        logic               deg;
        logic [2:0][31:0]   v;
    } t_job;

    function automatic logic signed [15:0] coef(input logic [47:0] row, input int k);
        coef = $signed(row[16*k +: 16]);
    endfunction

    function automatic logic signed [31:0] pos(input t_cfg c, input int k);
        logic signed [31:0] r;
        case (k)
            0:       r = c.pos_x;
            1:       r = c.pos_y;
            default: r = c.pos_z;
        endcase
        pos = r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [SAT_IN_W-1:0] x);
        logic signed [SAT_IN_W-1:0] hi;
        logic signed [SAT_IN_W-1:0] lo;
        hi = SAT_IN_W'(32'sh7fff_ffff);
        lo = ~hi;
        if (x > hi) begin
            sat32 = 32'sh7fff_ffff;
        end else if (x < lo) begin
            sat32 = 32'sh8000_0000;
        end else begin
            sat32 = x[31:0];
        end
    endfunction

endpackage
`default_nettype wire

/* rtl/perspective_point_projector_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// perspective_point_projector_core
// Projects a Q16.16 world point onto the camera plane and screen.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel is a queue write side: present point_x/y/z with push; the
//   point transfers at a clock edge where push is high and full is low.
//   Result channel is a queue read side: while empty is low the oldest result
//   (screen_x, screen_y, degenerate) is on the ports; it transfers at a clock
//   edge where pop is high.
//   Configuration: write register i_cfg_idx with i_cfg_data when i_cfg_we is
//   high; unknown indexes are ignored. Write only while the block is idle.
// Throughput: one point per cycle when nothing stalls. The divider is 31
//   pipelined restoring steps, one quotient bit per stage, so it never
//   limits the rate.
// Path from input transfer to empty going low: 3 front stages (the first
//   loaded at the transfer edge), queue, 32 divider stages, 5 back stages, buffer.
// Reset: synchronous; drops all items in flight and loads the default
//   camera (origin, looking along y, unit zoom, x/z basis).
// Stall: when pop is held low the back stalls once its result buffer is
//   full, the queue fills, and then full rises to hold the source.
// ----------------------------------------------------------------------------
module perspective_point_projector_core
    import ppp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [47:0]        i_cfg_data,
    input  wire logic               push,
    output logic                    full,
    input  wire logic signed [31:0] i_point_x,
    input  wire logic signed [31:0] i_point_y,
    input  wire logic signed [31:0] i_point_z,
    output logic                    empty,
    input  wire logic               pop,
    output logic signed [31:0]      o_screen_x,
    output logic signed [31:0]      o_screen_y,
    output logic                    o_degenerate
);

    t_cfg r_cfg;
    logic q_push, q_pop, q_full, q_empty;
    t_job q_in, q_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pos_x <= '0;
            r_cfg.pos_y <= '0;
            r_cfg.pos_z <= '0;
            r_cfg.dir   <= 48'h0000_4000_0000;
            r_cfg.zoom  <= 31'h0001_0000;
            r_cfg.row_u <= 48'h0000_0000_4000;
            r_cfg.row_w <= 48'h4000_0000_0000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_POS_X: r_cfg.pos_x <= $signed(i_cfg_data[31:0]);
                REG_POS_Y: r_cfg.pos_y <= $signed(i_cfg_data[31:0]);
                REG_POS_Z: r_cfg.pos_z <= $signed(i_cfg_data[31:0]);
                REG_DIR:   r_cfg.dir   <= i_cfg_data;
                REG_ZOOM:  r_cfg.zoom  <= i_cfg_data[30:0];
                REG_ROW_U: r_cfg.row_u <= i_cfg_data;
                REG_ROW_W: r_cfg.row_w <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // front: accept points, form numerator and denominator
    ppp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .push      (push),
        .full      (full),
        .i_point_x (i_point_x),
        .i_point_y (i_point_y),
        .i_point_z (i_point_z),
        .i_q_full  (q_full),
        .o_q_push  (q_push),
        .o_q_job   (q_in)
    );

    // decouple front and back
    ppp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_job   (q_out)
    );

    // back: divide, intersect, map to screen, buffer results
    ppp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_q_empty    (q_empty),
        .i_q_job      (q_out),
        .o_q_pop      (q_pop),
        .empty        (empty),
        .pop          (pop),
        .o_screen_x   (o_screen_x),
        .o_screen_y   (o_screen_y),
        .o_degenerate (o_degenerate)
    );

endmodule
`default_nettype wire

/* rtl/ppp_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ppp_front
// Accepts points and forms the numerator and denominator magnitudes.
// ----------------------------------------------------------------------------
module ppp_front
    import ppp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cfg               i_cfg,
    input  wire logic               push,
    output logic                    full,
    input  wire logic signed [31:0] i_point_x,
    input  wire logic signed [31:0] i_point_y,
    input  wire logic signed [31:0] i_point_z,
    input  wire logic               i_q_full,
    output logic                    o_q_push,
    output t_job                    o_q_job
);

    logic                     fe;
    logic                     r_a_vld, r_b_vld, r_c_vld;
    logic signed [31:0]       r_a_v [3];
    logic signed [31:0]       r_b_v [3];
    logic signed [31:0]       r_c_v [3];
    logic signed [47:0]       r_b_dv [3];
    logic signed [48:0]       r_b_dd [3];
    logic signed [SUM_W-1:0]  r_c_num, r_c_den;
    logic signed [SUM_W-1:0]  n_num, n_den, abs_num, abs_den;

    // hold every stage while the queue cannot take the last one
    assign fe       = !(r_c_vld && i_q_full);
    assign full     = !fe;
    assign o_q_push = r_c_vld && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else if (fe) begin
            r_a_vld <= push;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    always_comb begin
        n_num = $signed(SUM_W'({i_cfg.zoom, {COEF_FRAC{1'b0}}}));
        n_den = '0;
        for (int k = 0; k < 3; k++) begin
            n_num = n_num - SUM_W'(r_b_dv[k]);
            n_den = n_den + SUM_W'(r_b_dd[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (fe) begin
            r_a_v[0] <= i_point_x;
            r_a_v[1] <= i_point_y;
            r_a_v[2] <= i_point_z;
            for (int k = 0; k < 3; k++) begin
                r_b_v[k]  <= r_a_v[k];
                r_b_dv[k] <= coef(i_cfg.dir, k) * r_a_v[k];
                r_b_dd[k] <= coef(i_cfg.dir, k) *
                             ($signed(33'(pos(i_cfg, k))) - $signed(33'(r_a_v[k])));
                r_c_v[k]  <= r_b_v[k];
            end
            r_c_num <= n_num;
            r_c_den <= n_den;
        end
    end

    assign abs_num = r_c_num[SUM_W-1] ? -r_c_num : r_c_num;
    assign abs_den = r_c_den[SUM_W-1] ? -r_c_den : r_c_den;

    always_comb begin
        o_q_job.an  = abs_num[MAG_W-1:0];
        o_q_job.ad  = abs_den[MAG_W-1:0];
        o_q_job.neg = r_c_num[SUM_W-1] ^ r_c_den[SUM_W-1];
        o_q_job.deg = (r_c_den == '0);
        for (int k = 0; k < 3; k++) begin
            o_q_job.v[k] = r_c_v[k];
        end
    end

endmodule
`default_nettype wire

/* rtl/ppp_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ppp_queue
// Short register queue of jobs between the front and the back.
// ----------------------------------------------------------------------------
module ppp_queue
    import ppp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_job      o_job
);

    t_job               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp, r_rp;
    logic [Q_CNT_W-1:0] r_cnt;
    logic               do_push, do_pop;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 1'b1;
            if (do_pop)  r_rp <= r_rp + 1'b1;
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_job;
    end

endmodule
`default_nettype wire

/* rtl/ppp_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ppp_back
// Pipelined divide, plane intersection, basis mapping and result buffer.
// ----------------------------------------------------------------------------
module ppp_back
    import ppp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire logic i_q_empty,
    input  wire t_job i_q_job,
    output logic      o_q_pop,
    output logic      empty,
    input  wire logic pop,
    output logic signed [31:0] o_screen_x,
    output logic signed [31:0] o_screen_y,
    output logic               o_degenerate
);

    typedef struct packed {
        logic [MAG_W-1:0]     rem;
        logic [MAG_W-1:0]     ad;
        logic [DIV_STEPS-1:0] lo;
        logic [DIV_STEPS-1:0] q;
        logic                 neg;
        logic                 sat;
        logic                 deg;
        logic [2:0][31:0]     v;
    } t_dstage;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               deg;
    } t_res;

    logic    be;
    t_dstage r_ds   [DIV_STEPS+1];
    logic    r_dvld [DIV_STEPS+1];
    t_dstage n_ds   [DIV_STEPS+1];
    t_dstage d0;

    logic                    r_l_vld, r_m_vld, r_p_vld, r_r_vld, r_s_vld;
    logic signed [31:0]      r_l_lam;
    logic signed [32:0]      r_l_diff [3];
    logic signed [31:0]      r_l_v [3], r_m_v [3];
    logic                    r_l_deg, r_m_deg, r_p_deg, r_r_deg;
    logic signed [64:0]      r_m_prod [3];
    logic signed [31:0]      r_p [3];
    logic signed [47:0]      r_r_pu [3], r_r_pw [3];
    t_res                    r_s, n_s;
    logic [DIV_STEPS-1:0]    mag;
    logic signed [SUM_W-1:0] su, sw;

    t_res     r_ob [2];
    logic     r_ob_wp, r_ob_rp;
    logic [1:0] r_ob_cnt;
    logic     ob_full, ob_push, ob_pop;
    t_dstage  last;

    assign ob_full = (r_ob_cnt == 2'd2);
    assign be      = !(r_s_vld && ob_full);
    assign o_q_pop = be && !i_q_empty;
    assign last    = r_ds[DIV_STEPS];

    // seed the divider: top part of |num|*2^F, remaining bits shift in later
    always_comb begin
        logic [MAG_W+FRAC_BITS-1:0] dvd;
        dvd       = {i_q_job.an, {FRAC_BITS{1'b0}}};
        d0.rem    = MAG_W'(i_q_job.an >> (DIV_STEPS - FRAC_BITS));
        d0.ad     = i_q_job.ad;
        d0.lo     = dvd[DIV_STEPS-1:0];
        d0.q      = '0;
        d0.neg    = i_q_job.neg;
        d0.sat    = (MAG_W'(i_q_job.an >> (DIV_STEPS - FRAC_BITS)) >= i_q_job.ad);
        d0.deg    = i_q_job.deg;
        d0.v      = i_q_job.v;
        n_ds[0]   = d0;
    end

    for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
        always_comb begin
            logic [MAG_W:0] rs;
            logic           ge;
            rs         = {r_ds[k-1].rem, r_ds[k-1].lo[DIV_STEPS-1]};
            ge         = (rs >= {1'b0, r_ds[k-1].ad});
            n_ds[k]    = r_ds[k-1];
            n_ds[k].rem = ge ? MAG_W'(rs - {1'b0, r_ds[k-1].ad}) : MAG_W'(rs);
            n_ds[k].lo = {r_ds[k-1].lo[DIV_STEPS-2:0], 1'b0};
            n_ds[k].q  = {r_ds[k-1].q[DIV_STEPS-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DIV_STEPS; k++) r_dvld[k] <= 1'b0;
            r_l_vld <= 1'b0;
            r_m_vld <= 1'b0;
            r_p_vld <= 1'b0;
            r_r_vld <= 1'b0;
            r_s_vld <= 1'b0;
        end else if (be) begin
            r_dvld[0] <= !i_q_empty;
            for (int k = 1; k <= DIV_STEPS; k++) r_dvld[k] <= r_dvld[k-1];
            r_l_vld <= r_dvld[DIV_STEPS];
            r_m_vld <= r_l_vld;
            r_p_vld <= r_m_vld;
            r_r_vld <= r_p_vld;
            r_s_vld <= r_r_vld;
        end
    end

    assign mag = last.sat ? {DIV_STEPS{1'b1}} : last.q;

    always_comb begin
        su = '0;
        sw = '0;
        for (int k = 0; k < 3; k++) begin
            su = su + SUM_W'(r_r_pu[k]);
            sw = sw + SUM_W'(r_r_pw[k]);
        end
        su = su >>> COEF_FRAC;
        sw = sw >>> COEF_FRAC;
        n_s.x   = r_r_deg ? '0 : sat32(SAT_IN_W'(SCREEN_X_FX - su));
        n_s.y   = r_r_deg ? '0 : sat32(SAT_IN_W'(SCREEN_Y_FX - sw));
        n_s.deg = r_r_deg;
    end

    always_ff @(posedge i_clk) begin
        if (be) begin
            for (int k = 0; k <= DIV_STEPS; k++) r_ds[k] <= n_ds[k];
            r_l_lam <= last.neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
            r_l_deg <= last.deg;
            for (int k = 0; k < 3; k++) begin
                r_l_v[k]    <= $signed(last.v[k]);
                r_l_diff[k] <= $signed(33'(pos(i_cfg, k))) - $signed(33'($signed(last.v[k])));
                r_m_prod[k] <= r_l_lam * r_l_diff[k];
                r_m_v[k]    <= r_l_v[k];
                r_p[k]      <= sat32(SAT_IN_W'(r_m_prod[k] >>> FRAC_BITS) +
                                     SAT_IN_W'(r_m_v[k]));
                r_r_pu[k]   <= coef(i_cfg.row_u, k) * r_p[k];
                r_r_pw[k]   <= coef(i_cfg.row_w, k) * r_p[k];
            end
            r_m_deg <= r_l_deg;
            r_p_deg <= r_m_deg;
            r_r_deg <= r_p_deg;
            r_s     <= n_s;
        end
    end

    // two-entry result buffer
    assign ob_push = r_s_vld && !ob_full;
    assign empty   = (r_ob_cnt == 2'd0);
    assign ob_pop  = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_wp  <= 1'b0;
            r_ob_rp  <= 1'b0;
            r_ob_cnt <= 2'd0;
        end else begin
            if (ob_push) r_ob_wp <= !r_ob_wp;
            if (ob_pop)  r_ob_rp <= !r_ob_rp;
            if (ob_push && !ob_pop) begin
                r_ob_cnt <= r_ob_cnt + 2'd1;
            end else if (ob_pop && !ob_push) begin
                r_ob_cnt <= r_ob_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ob_push) r_ob[r_ob_wp] <= r_s;
    end

    assign o_screen_x   = r_ob[r_ob_rp].x;
    assign o_screen_y   = r_ob[r_ob_rp].y;
    assign o_degenerate = r_ob[r_ob_rp].deg;

endmodule
`default_nettype wire
